// ----- hw/rtl/bqd_pkg.sv -----
`default_nettype none

package bqd_pkg;

  // Item and result field widths.
  localparam int ACT_W   = 8;
  localparam int WT_W    = 4;
  localparam int SCALE_W = 16;
  localparam int ACC_W   = 64;

  // Block geometry and fixed-point formats.
  localparam int BLOCK_SIZE      = 32;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int ACC_FRAC        = 24;

  // Position inside the open block pair never reaches BLOCK_SIZE.
  localparam int POS_W = $clog2(BLOCK_SIZE);

  // Exact per-block sums: signed act times unsigned nibble, summed over a block.
  localparam int DOT_W  = ACT_W + WT_W + $clog2(BLOCK_SIZE);
  localparam int ASUM_W = ACT_W + $clog2(BLOCK_SIZE);

  // Shared multiplier: an act scale or a scale product (A) times a weight scale or a block sum (B).
  localparam int PROD_W    = 2 * SCALE_W;
  localparam int MUL_A_W   = PROD_W;
  localparam int MUL_B_W   = (DOT_W > SCALE_W) ? DOT_W : SCALE_W;
  localparam int MUL_OUT_W = MUL_A_W + MUL_B_W;

  // Four terms of a pair are summed exactly.
  localparam int SUM_W = MUL_OUT_W + 2;

  // Alignment of the pair sum to the accumulator's fraction bits.
  localparam int ALIGN_SHIFT = ACC_FRAC - 2 * SCALE_FRAC_BITS;
  localparam int ALIGN_SHL   = (ALIGN_SHIFT > 0) ? ALIGN_SHIFT : 0;
  localparam int ALIGN_SHR   = (ALIGN_SHIFT < 0) ? -ALIGN_SHIFT : 0;
  localparam int ALIGN_W     = SUM_W + ALIGN_SHL;
  localparam int EXT_W       = ((ALIGN_W > ACC_W) ? ALIGN_W : ACC_W) + 1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC0,
    ST_T0,
    ST_SC1,
    ST_T1,
    ST_SC2,
    ST_T2,
    ST_SC3,
    ST_T3,
    ST_ADD,
    ST_ALIGN,
    ST_ACC,
    ST_EMIT
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MS_SW0,
    MS_OW0,
    MS_SW1,
    MS_OW1,
    MS_DOT0,
    MS_ASUM0,
    MS_DOT1,
    MS_ASUM1
  } mul_sel_t;

  // Control from the sequencer to the block sums and the pair datapath.
  typedef struct packed {
    logic     item_en;
    logic     pair_clear;
    logic     scale_ld;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_load;
    logic     sum_add;
    logic     align_en;
    logic     acc_en;
    logic     emit;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bqd_block_sums.sv -----
`default_nettype none

module bqd_block_sums (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bqd_pkg::seq_ctrl_t                 ctrl,
  input  wire logic signed [bqd_pkg::ACT_W-1:0]   act_first,
  input  wire logic signed [bqd_pkg::ACT_W-1:0]   act_second,
  input  wire logic        [2*bqd_pkg::WT_W-1:0]  weight_pair,
  output logic signed      [bqd_pkg::DOT_W-1:0]   dot_first,
  output logic signed      [bqd_pkg::DOT_W-1:0]   dot_second,
  output logic signed      [bqd_pkg::ASUM_W-1:0]  act_sum_first,
  output logic signed      [bqd_pkg::ASUM_W-1:0]  act_sum_second
);

  logic signed [bqd_pkg::ACT_W+bqd_pkg::WT_W:0] term_first;
  logic signed [bqd_pkg::ACT_W+bqd_pkg::WT_W:0] term_second;

  // Each nibble is an unsigned weight; a zero sign bit keeps it positive.
  always_comb begin
    term_first  = act_first  * $signed({1'b0, weight_pair[bqd_pkg::WT_W-1:0]});
    term_second = act_second * $signed({1'b0, weight_pair[2*bqd_pkg::WT_W-1:bqd_pkg::WT_W]});
  end

  // Exact block sums, cleared when the pair's last term is added into the pair sum.
  always_ff @(posedge clk) begin
    if (rst || ctrl.pair_clear) begin
      dot_first      <= '0;
      dot_second     <= '0;
      act_sum_first  <= '0;
      act_sum_second <= '0;
    end else if (ctrl.item_en) begin
      dot_first      <= dot_first  + bqd_pkg::DOT_W'(term_first);
      dot_second     <= dot_second + bqd_pkg::DOT_W'(term_second);
      act_sum_first  <= act_sum_first  + bqd_pkg::ASUM_W'(act_first);
      act_sum_second <= act_sum_second + bqd_pkg::ASUM_W'(act_second);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bqd_pair_mac.sv -----
`default_nettype none

module bqd_pair_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bqd_pkg::seq_ctrl_t                  ctrl,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_act_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_act_second,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_wt_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_wt_second,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  offset_wt_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  offset_wt_second,
  input  wire logic signed [bqd_pkg::DOT_W-1:0]    dot_first,
  input  wire logic signed [bqd_pkg::DOT_W-1:0]    dot_second,
  input  wire logic signed [bqd_pkg::ASUM_W-1:0]   act_sum_first,
  input  wire logic signed [bqd_pkg::ASUM_W-1:0]   act_sum_second,
  output logic signed      [bqd_pkg::ACC_W-1:0]    accumulator,
  output logic                                     sat_flag
);

  localparam logic signed [bqd_pkg::EXT_W-1:0] EXT_MAX =
    {{(bqd_pkg::EXT_W-bqd_pkg::ACC_W+1){1'b0}}, {(bqd_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [bqd_pkg::EXT_W-1:0] EXT_MIN = ~EXT_MAX;

  // Scales of the closing item.
  logic signed [bqd_pkg::SCALE_W-1:0] sa0;
  logic signed [bqd_pkg::SCALE_W-1:0] sa1;
  logic signed [bqd_pkg::SCALE_W-1:0] sw0;
  logic signed [bqd_pkg::SCALE_W-1:0] sw1;
  logic signed [bqd_pkg::SCALE_W-1:0] ow0;
  logic signed [bqd_pkg::SCALE_W-1:0] ow1;

  logic signed [bqd_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [bqd_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [bqd_pkg::MUL_OUT_W-1:0] prod;
  logic signed [bqd_pkg::SUM_W-1:0]     sum;
  logic signed [bqd_pkg::EXT_W-1:0]     shifted;
  logic signed [bqd_pkg::ACC_W-1:0]     aligned;
  logic signed [bqd_pkg::ACC_W-1:0]     aligned_next;
  logic                                 align_sat;
  logic signed [bqd_pkg::ACC_W:0]       acc_sum;
  logic signed [bqd_pkg::ACC_W-1:0]     accumulator_next;
  logic                                 acc_sat;

  // Scales are captured when the closing item is taken.
  always_ff @(posedge clk) begin
    if (ctrl.scale_ld) begin
      sa0 <= scale_act_first;
      sa1 <= scale_act_second;
      sw0 <= scale_wt_first;
      sw1 <= scale_wt_second;
      ow0 <= offset_wt_first;
      ow1 <= offset_wt_second;
    end
  end

  // Operand selection: a scale pair, or the last scale product times a block sum.
  always_comb begin
    unique case (ctrl.mul_sel)
      bqd_pkg::MS_SW0: begin
        mul_a = bqd_pkg::MUL_A_W'(sa0);
        mul_b = bqd_pkg::MUL_B_W'(sw0);
      end
      bqd_pkg::MS_OW0: begin
        mul_a = bqd_pkg::MUL_A_W'(sa0);
        mul_b = bqd_pkg::MUL_B_W'(ow0);
      end
      bqd_pkg::MS_SW1: begin
        mul_a = bqd_pkg::MUL_A_W'(sa1);
        mul_b = bqd_pkg::MUL_B_W'(sw1);
      end
      bqd_pkg::MS_OW1: begin
        mul_a = bqd_pkg::MUL_A_W'(sa1);
        mul_b = bqd_pkg::MUL_B_W'(ow1);
      end
      bqd_pkg::MS_DOT0: begin
        mul_a = $signed(prod[bqd_pkg::PROD_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(dot_first);
      end
      bqd_pkg::MS_ASUM0: begin
        mul_a = $signed(prod[bqd_pkg::PROD_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(act_sum_first);
      end
      bqd_pkg::MS_DOT1: begin
        mul_a = $signed(prod[bqd_pkg::PROD_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(dot_second);
      end
      bqd_pkg::MS_ASUM1: begin
        mul_a = $signed(prod[bqd_pkg::PROD_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(act_sum_second);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier with a registered product, and the exact pair sum.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.sum_load) begin
      sum <= bqd_pkg::SUM_W'(prod);
    end else if (ctrl.sum_add) begin
      sum <= sum + bqd_pkg::SUM_W'(prod);
    end
  end

  // Align the pair sum to the accumulator format; right shifts round down.
  always_comb begin
    shifted   = (bqd_pkg::EXT_W'(sum) <<< bqd_pkg::ALIGN_SHL) >>> bqd_pkg::ALIGN_SHR;
    align_sat = 1'b0;
    if (shifted > EXT_MAX) begin
      aligned_next = EXT_MAX[bqd_pkg::ACC_W-1:0];
      align_sat    = 1'b1;
    end else if (shifted < EXT_MIN) begin
      aligned_next = EXT_MIN[bqd_pkg::ACC_W-1:0];
      align_sat    = 1'b1;
    end else begin
      aligned_next = shifted[bqd_pkg::ACC_W-1:0];
    end
  end

  // Saturating add of the aligned pair into the running total.
  always_comb begin
    acc_sum = (bqd_pkg::ACC_W + 1)'(accumulator) + (bqd_pkg::ACC_W + 1)'(aligned);
    acc_sat = acc_sum[bqd_pkg::ACC_W] != acc_sum[bqd_pkg::ACC_W-1];
    if (acc_sat) begin
      accumulator_next = {acc_sum[bqd_pkg::ACC_W], {(bqd_pkg::ACC_W-1){~acc_sum[bqd_pkg::ACC_W]}}};
    end else begin
      accumulator_next = acc_sum[bqd_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.align_en) begin
      aligned <= aligned_next;
    end
  end

  // Running total and sticky saturation flag, cleared once the result is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst || ctrl.emit) begin
      accumulator <= '0;
      sat_flag    <= 1'b0;
    end else begin
      if (ctrl.align_en && align_sat) begin
        sat_flag <= 1'b1;
      end
      if (ctrl.acc_en) begin
        accumulator <= accumulator_next;
        if (acc_sat) begin
          sat_flag <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bqd_ctrl.sv -----
`default_nettype none

module bqd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               last_item,
  input  wire logic               out_free,
  output logic                    in_stall,
  output bqd_pkg::seq_ctrl_t      ctrl
);

  bqd_pkg::state_t              state;
  bqd_pkg::state_t              state_next;
  logic [bqd_pkg::POS_W-1:0]    position;
  logic                         last_pair;
  logic                         close;

  // A pair closes when it is full or on the final item.
  assign close = last_item || (position == bqd_pkg::POS_W'(bqd_pkg::BLOCK_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bqd_pkg::ST_IDLE;
      position  <= '0;
      last_pair <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.item_en) begin
        position <= close ? '0 : position + 1'b1;
        if (close) begin
          last_pair <= last_item;
        end
      end
    end
  end

  // Pair closing sequence: four scale products, each followed by its term.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ctrl       = '0;
    ctrl.mul_sel = bqd_pkg::MS_SW0;
    unique case (state)
      bqd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.item_en = 1'b1;
          if (close) begin
            ctrl.scale_ld = 1'b1;
            state_next    = bqd_pkg::ST_SC0;
          end
        end
      end
      bqd_pkg::ST_SC0: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_SW0;
        state_next   = bqd_pkg::ST_T0;
      end
      bqd_pkg::ST_T0: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_DOT0;
        state_next   = bqd_pkg::ST_SC1;
      end
      bqd_pkg::ST_SC1: begin
        ctrl.sum_load = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = bqd_pkg::MS_OW0;
        state_next    = bqd_pkg::ST_T1;
      end
      bqd_pkg::ST_T1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_ASUM0;
        state_next   = bqd_pkg::ST_SC2;
      end
      bqd_pkg::ST_SC2: begin
        ctrl.sum_add = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_SW1;
        state_next   = bqd_pkg::ST_T2;
      end
      bqd_pkg::ST_T2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_DOT1;
        state_next   = bqd_pkg::ST_SC3;
      end
      bqd_pkg::ST_SC3: begin
        ctrl.sum_add = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_OW1;
        state_next   = bqd_pkg::ST_T3;
      end
      bqd_pkg::ST_T3: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bqd_pkg::MS_ASUM1;
        state_next   = bqd_pkg::ST_ADD;
      end
      bqd_pkg::ST_ADD: begin
        ctrl.sum_add    = 1'b1;
        ctrl.pair_clear = 1'b1;
        state_next      = bqd_pkg::ST_ALIGN;
      end
      bqd_pkg::ST_ALIGN: begin
        ctrl.align_en = 1'b1;
        state_next    = bqd_pkg::ST_ACC;
      end
      bqd_pkg::ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_next  = last_pair ? bqd_pkg::ST_EMIT : bqd_pkg::ST_IDLE;
      end
      bqd_pkg::ST_EMIT: begin
        if (out_free) begin
          ctrl.emit  = 1'b1;
          state_next = bqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bqd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/block_quant_int8_int4_dot_product.sv -----
// Block-quantized int8 x int4 dot product. Each transfer brings one byte position of a block
// pair; an item that does not close a pair is taken without a stall. An item that closes a pair
// (the BLOCK_SIZE-th of the pair, or any item with last_item set) holds in_stall high while
// one shared 32 x 17 multiplier forms the four scale products and the four scaled terms, and
// the pair sum is aligned and added to the saturating 64-bit total; on a last item the sequencer
// then loads the result register, waiting while that register still holds an untaken result.
// A finished result waits in the output register while new items are taken.

`default_nettype none

module block_quant_int8_int4_dot_product (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [bqd_pkg::ACT_W-1:0]    act_first,
  input  wire logic signed [bqd_pkg::ACT_W-1:0]    act_second,
  input  wire logic        [2*bqd_pkg::WT_W-1:0]   weight_pair,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_act_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_act_second,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_wt_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  scale_wt_second,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  offset_wt_first,
  input  wire logic signed [bqd_pkg::SCALE_W-1:0]  offset_wt_second,
  input  wire logic                                last_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [bqd_pkg::ACC_W-1:0]    dot_value,
  output logic                                     overflowed
);

  bqd_pkg::seq_ctrl_t                   ctrl;
  logic                                 out_free;
  logic signed [bqd_pkg::DOT_W-1:0]     dot_first;
  logic signed [bqd_pkg::DOT_W-1:0]     dot_second;
  logic signed [bqd_pkg::ASUM_W-1:0]    act_sum_first;
  logic signed [bqd_pkg::ASUM_W-1:0]    act_sum_second;
  logic signed [bqd_pkg::ACC_W-1:0]     accumulator;
  logic                                 sat_flag;

  // The result register can take a new value when empty or being transferred out.
  assign out_free = !out_valid || !out_stall;

  bqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_item (last_item),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  bqd_block_sums u_sums (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .act_first      (act_first),
    .act_second     (act_second),
    .weight_pair    (weight_pair),
    .dot_first      (dot_first),
    .dot_second     (dot_second),
    .act_sum_first  (act_sum_first),
    .act_sum_second (act_sum_second)
  );

  bqd_pair_mac u_mac (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .scale_act_first  (scale_act_first),
    .scale_act_second (scale_act_second),
    .scale_wt_first   (scale_wt_first),
    .scale_wt_second  (scale_wt_second),
    .offset_wt_first  (offset_wt_first),
    .offset_wt_second (offset_wt_second),
    .dot_first        (dot_first),
    .dot_second       (dot_second),
    .act_sum_first    (act_sum_first),
    .act_sum_second   (act_sum_second),
    .accumulator      (accumulator),
    .sat_flag         (sat_flag)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      dot_value  <= accumulator;
      overflowed <= sat_flag;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bqd_checker.sv -----
`default_nettype none

module bqd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              last_item,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [bqd_pkg::ACC_W-1:0]  dot_value,
  input wire logic                              overflowed
);

  // Reset leaves the block ready and with no result pending.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A final item always starts the closing sequence, so the input stalls next.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_item |=> in_stall)
    else $error("input not stalled after final item transfer");

  // A new result appears as the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while input stalled");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dot_value) && $stable(overflowed))
    else $error("stalled result changed");

endmodule

bind block_quant_int8_int4_dot_product bqd_checker u_bqd_checker (.*);

`default_nettype wire
